[src/tel_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tel_pkg
// Shared types and constants of the throttled event log.
// ----------------------------------------------------------------------------
package tel_pkg;

	localparam int ID_W   = 32;
	localparam int TIME_W = 48;
	localparam int CNT_W  = 9;
	localparam int MIN_W  = 32;
	localparam int CFG_W  = 32;

	localparam logic       MODE_RAISE = 1'b0;
	localparam logic       MODE_ACK   = 1'b1;

	localparam logic       REG_MIN_INTERVAL = 1'b0;
	localparam logic       REG_MAX_HISTORY  = 1'b1;

	localparam logic [MIN_W-1:0] MIN_INTERVAL_RST = MIN_W'(1000);
	localparam logic [CNT_W-1:0] MAX_HISTORY_RST  = CNT_W'(256);

	typedef struct packed {
		logic              mode;
		logic [3:0]        event_type;
		logic [1:0]        severity;
		logic [TIME_W-1:0] time_ms;
		logic [ID_W-1:0]   ack_id;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]  assigned_id;
		logic             ack_ok;
		logic [CNT_W-1:0] total_count;
		logic [CNT_W-1:0] unacked_count;
	} rsp_t;

	typedef struct packed {
		logic            valid;
		logic            acked;
		logic [ID_W-1:0] id;
	} cell_t;

	typedef struct packed {
		logic            shift;
		logic            append;
		logic            mark;
		logic [ID_W-1:0] new_id;
		logic [ID_W-1:0] cmp_id;
	} chain_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_APPEND,
		ST_TRIM,
		ST_ACK,
		ST_DONE
	} state_t;

endpackage

[src/tel_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tel_cell
// One history entry; takes its upper neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module tel_cell import tel_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  chain_cmd_t cmd,
	input  logic       sel,
	input  logic       pick,
	input  cell_t      nxt,
	output cell_t      cur,
	output logic       match_q
);

	logic            valid_q;
	logic            acked_q;
	logic [ID_W-1:0] id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			acked_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (cmd.shift) begin
				valid_q <= nxt.valid;
				acked_q <= nxt.acked;
			end else if (cmd.append && sel) begin
				valid_q <= 1'b1;
				acked_q <= 1'b0;
			end else if (cmd.mark && pick) begin
				acked_q <= 1'b1;
			end
			match_q <= valid_q && (id_q == cmd.cmp_id);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			id_q <= nxt.id;
		end else if (cmd.append && sel) begin
			id_q <= cmd.new_id;
		end
	end

	assign cur = '{valid: valid_q, acked: acked_q, id: id_q};

endmodule

[src/tel_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tel_chain
// Row of entry cells, oldest at cell 0; first-match pick for acknowledge.
// ----------------------------------------------------------------------------
module tel_chain import tel_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int CW    = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  chain_cmd_t    cmd,
	input  logic [CW-1:0] count,
	output logic          ack_hit,
	output logic          head_acked
);

	cell_t            cells [DEPTH];
	logic [DEPTH-1:0] match;
	logic [DEPTH-1:0] first;
	logic [DEPTH-1:0] unacked;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_t nxt;
		if (i < DEPTH - 1) begin : g_mid
			assign nxt = cells[i+1];
		end else begin : g_end
			assign nxt = '0;
		end
		assign unacked[i] = ~cells[i].acked;
		tel_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.sel     (count == CW'(i)),
			.pick    (first[i]),
			.nxt     (nxt),
			.cur     (cells[i]),
			.match_q (match[i])
		);
	end

	// lowest set bit = oldest matching entry
	assign first      = match & (~match + DEPTH'(1));
	assign ack_hit    = |(first & unacked);
	assign head_acked = cells[0].acked;

endmodule

[src/throttled_event_log_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// throttled_event_log_unit
// Event log with per-type rate limiting, history ring and acknowledge.
// ----------------------------------------------------------------------------
//  channel | signals                     | role
//  req     | req_valid, req_ready, req   | raise / acknowledge items in
//  rsp     | rsp_valid, rsp_ready, rsp   | one result item per request
//  cfg     | cfg_we, cfg_index, cfg_data | register writes, no wait
//
// One item at a time. Throttled raise: steps EXEC, DONE; acknowledge: EXEC,
// ACK, DONE; accepted raise: EXEC, APPEND, TRIM, DONE, where TRIM repeats
// once per entry trimmed to the history limit. The eviction on a full ring
// rides in the first step. The shifting cell row evicts one entry per cycle.
// Reset clears the whole row at once; no clearing pass.
// A stalled result holds in the output register; the next item is taken
// meanwhile and waits in its last step until the output frees.
// ----------------------------------------------------------------------------
module throttled_event_log_unit import tel_pkg::*; #(
	parameter int HISTORY_DEPTH = 256,
	parameter int TYPE_COUNT    = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam int LW = (CW > CNT_W) ? CW : CNT_W;
	localparam int TW = $clog2(TYPE_COUNT);

	state_t state_q, state_d;

	logic [MIN_W-1:0]  min_int_q;
	logic [CNT_W-1:0]  max_hist_q;
	req_t              item_q;
	logic [TIME_W-1:0] last_time_q [TYPE_COUNT];
	logic [TYPE_COUNT-1:0] seen_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     pend_q;
	logic [ID_W-1:0]   next_id_q;
	logic [ID_W-1:0]   res_id_q;
	logic              res_ok_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [TW-1:0]     type_idx;
	logic [TIME_W-1:0] elapsed;
	logic              throttled;
	logic              full;
	logic [LW-1:0]     hist_ext;
	logic [LW-1:0]     limit;
	logic              over;
	logic              out_free;
	logic              accept;
	logic              do_evict, do_append, do_mark, load_rsp, id_step, set_res;
	logic              ack_hit, head_acked;
	chain_cmd_t        cmd;

	assign accept   = req_valid && req_ready;
	assign out_free = !rsp_valid_q || rsp_ready;

	// type folded into the table through a constant lookup
	always_comb begin
		type_idx = '0;
		for (int k = 0; k < 16; k++) begin
			if (item_q.event_type == 4'(k)) type_idx = TW'(k % TYPE_COUNT);
		end
	end

	assign elapsed   = item_q.time_ms - last_time_q[type_idx];
	assign throttled = seen_q[type_idx] && (elapsed < TIME_W'(min_int_q));
	assign full      = count_q == CW'(HISTORY_DEPTH);
	assign hist_ext  = LW'(max_hist_q);
	assign limit     = (hist_ext > LW'(HISTORY_DEPTH)) ? LW'(HISTORY_DEPTH) : hist_ext;
	assign over      = LW'(count_q) > limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		do_evict  = 1'b0;
		do_append = 1'b0;
		do_mark   = 1'b0;
		load_rsp  = 1'b0;
		id_step   = 1'b0;
		set_res   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				set_res = 1'b1;
				if (item_q.mode == MODE_ACK) begin
					state_d = ST_ACK;
				end else begin
					id_step = 1'b1;
					if (throttled) begin
						state_d = ST_DONE;
					end else begin
						do_evict = full;
						state_d  = ST_APPEND;
					end
				end
			end
			ST_APPEND: begin
				do_append = 1'b1;
				state_d   = ST_TRIM;
			end
			ST_TRIM: begin
				if (over) begin
					do_evict = 1'b1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_ACK: begin
				do_mark = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_int_q  <= MIN_INTERVAL_RST;
			max_hist_q <= MAX_HISTORY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_INTERVAL: min_int_q  <= cfg_data[MIN_W-1:0];
				REG_MAX_HISTORY:  max_hist_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_q <= req;
		if (do_append) last_time_q[type_idx] <= item_q.time_ms;
		if (set_res) res_id_q <= (item_q.mode == MODE_RAISE && !throttled) ? next_id_q : '0;
		if (set_res) res_ok_q <= 1'b0;
		else if (do_mark) res_ok_q <= ack_hit;
		if (load_rsp) begin
			rsp_q.assigned_id   <= res_id_q;
			rsp_q.ack_ok        <= res_ok_q;
			rsp_q.total_count   <= CNT_W'(LW'(count_q));
			rsp_q.unacked_count <= CNT_W'(LW'(pend_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			count_q     <= '0;
			pend_q      <= '0;
			next_id_q   <= ID_W'(1);
			rsp_valid_q <= 1'b0;
		end else begin
			if (do_append) seen_q[type_idx] <= 1'b1;
			if (id_step) next_id_q <= (&next_id_q) ? ID_W'(1) : next_id_q + ID_W'(1);
			if (do_evict) begin
				count_q <= count_q - CW'(1);
				if (!head_acked && pend_q != '0) pend_q <= pend_q - CW'(1);
			end else if (do_append) begin
				count_q <= count_q + CW'(1);
				pend_q  <= pend_q + CW'(1);
			end else if (do_mark && ack_hit && pend_q != '0) begin
				pend_q <= pend_q - CW'(1);
			end
			if (load_rsp) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	assign cmd = '{shift: do_evict, append: do_append, mark: do_mark,
		new_id: res_id_q, cmp_id: item_q.ack_id};

	tel_chain #(
		.DEPTH (HISTORY_DEPTH),
		.CW    (CW)
	) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.count      (count_q),
		.ack_hit    (ack_hit),
		.head_acked (head_acked)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(HISTORY_DEPTH)) else $error("ring count above depth");
	a_pend_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= count_q) else $error("unacked count above held count");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req_ready) else $error("second item taken while busy");
	a_evict_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		do_evict |-> count_q != '0) else $error("evict on empty ring");

endmodule

[bench/throttled_event_log_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// throttled_event_log_unit_test
// Self-checking bench: directed raise/acknowledge items, then random traffic
// under several handshake idling phases, checked against an internal model.
// ----------------------------------------------------------------------------
module throttled_event_log_unit_test;
	import tel_pkg::*;

	localparam int DEPTH = 256;
	localparam int TYPES = 16;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_ready;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_ready;
	rsp_t             rsp;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;

	throttled_event_log_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// log model state
	logic [MIN_W-1:0]  mdl_min_interval;
	logic [CNT_W-1:0]  mdl_max_history;
	logic [TIME_W-1:0] mdl_last_time [TYPES];
	logic              mdl_type_seen [TYPES];
	logic [ID_W-1:0]   mdl_entry_id [DEPTH];
	logic              mdl_entry_acked [DEPTH];
	int unsigned       mdl_head;
	int unsigned       mdl_count;
	logic [ID_W-1:0]   mdl_next_id;
	int unsigned       mdl_pending;

	rsp_t        expected_rsps [$];
	int unsigned error_count;
	int unsigned rsp_count;
	int unsigned items_sent;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	logic [TIME_W-1:0] now_ms;

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
		error_count++;
	endtask

	function automatic void evict_oldest();
		if (mdl_count != 0) begin
			if (!mdl_entry_acked[mdl_head] && mdl_pending > 0)
				mdl_pending--;
			mdl_head = (mdl_head + 1) % DEPTH;
			mdl_count--;
		end
	endfunction

	function automatic rsp_t log_step(input req_t r);
		rsp_t o;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] elapsed;
		logic              throttled;
		int unsigned       limit;
		int unsigned       slot;
		int unsigned       t;
		o = '0;
		t = r.event_type % TYPES;
		if (r.mode == MODE_RAISE) begin
			id = mdl_next_id;
			throttled = 1'b0;
			mdl_next_id = (mdl_next_id == '1) ? ID_W'(1) : mdl_next_id + 1'b1;
			if (mdl_type_seen[t]) begin
				elapsed = r.time_ms - mdl_last_time[t];
				if (elapsed < {16'd0, mdl_min_interval})
					throttled = 1'b1;
			end
			if (!throttled) begin
				limit = (mdl_max_history > DEPTH) ? DEPTH : mdl_max_history;
				if (mdl_count >= DEPTH)
					evict_oldest();
				slot = (mdl_head + mdl_count) % DEPTH;
				mdl_entry_id[slot] = id;
				mdl_entry_acked[slot] = 1'b0;
				mdl_count++;
				mdl_pending++;
				mdl_last_time[t] = r.time_ms;
				mdl_type_seen[t] = 1'b1;
				while (mdl_count > limit)
					evict_oldest();
				o.assigned_id = id;
			end
		end else begin
			for (int i = 0; i < mdl_count; i++) begin
				slot = (mdl_head + i) % DEPTH;
				if (mdl_entry_id[slot] == r.ack_id) begin
					if (!mdl_entry_acked[slot]) begin
						mdl_entry_acked[slot] = 1'b1;
						if (mdl_pending > 0)
							mdl_pending--;
						o.ack_ok = 1'b1;
					end
					break;
				end
			end
		end
		o.total_count = CNT_W'(mdl_count);
		o.unacked_count = CNT_W'(mdl_pending);
		return o;
	endfunction

	// valid stays up after an accept until the next item or an idle cycle
	task automatic send_item(input req_t r);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (!req_ready);
		expected_rsps = {expected_rsps, log_step(r)};
		items_sent++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 20) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MIN_INTERVAL)
			mdl_min_interval = val;
		else
			mdl_max_history = val[CNT_W-1:0];
		@(posedge clk);
	endtask

	function automatic req_t make_raise(input logic [3:0] typ, input logic [TIME_W-1:0] tm);
		req_t r;
		r = '0;
		r.mode = MODE_RAISE;
		r.event_type = typ;
		r.severity = 2'($urandom_range(3));
		r.time_ms = tm;
		r.ack_id = $urandom;
		return r;
	endfunction

	function automatic req_t make_ack(input logic [ID_W-1:0] id);
		req_t r;
		r = '0;
		r.mode = MODE_ACK;
		r.event_type = 4'($urandom_range(15));
		r.time_ms = TIME_W'({$urandom, $urandom});
		r.ack_id = id;
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		rsp_t e;
		if (rsp_valid && rsp_ready) begin
			rsp_count++;
			if (expected_rsps.size() == 0) begin
				$display("unexpected result item at %0t", $realtime);
				error_count++;
			end else begin
				e = expected_rsps[0];
				expected_rsps.delete(0);
				if (rsp.assigned_id !== e.assigned_id)
					report_mismatch("assigned_id", rsp.assigned_id, e.assigned_id);
				if (rsp.ack_ok !== e.ack_ok)
					report_mismatch("ack_ok", rsp.ack_ok, e.ack_ok);
				if (rsp.total_count !== e.total_count)
					report_mismatch("total_count", rsp.total_count, e.total_count);
				if (rsp.unacked_count !== e.unacked_count)
					report_mismatch("unacked_count", rsp.unacked_count, e.unacked_count);
			end
		end
	end

	always @(posedge clk)
		rsp_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

	task automatic test_directed();
		send_item(make_ack(32'd1));                      // unknown id on empty log
		send_item(make_raise(4'd0, 48'd0));
		send_item(make_raise(4'd0, 48'd999));            // throttled
		send_item(make_raise(4'd0, 48'd1000));
		send_item(make_raise(4'd15, '1));
		send_item(make_raise(4'd15, 48'd998));           // wraps: elapsed 999
		send_item(make_raise(4'd15, 48'd999));
		send_item(make_ack(32'd2));                      // throttled id never held
		send_item(make_ack(32'd1));
		send_item(make_ack(32'd1));                      // already marked
		send_item(make_ack(32'hFFFF_FFFF));
		drain();
		write_reg(REG_MIN_INTERVAL, '1);
		write_reg(REG_MAX_HISTORY, CFG_W'(2));           // lowers, evicts nothing yet
		send_item(make_raise(4'd3, 48'd5));
		send_item(make_raise(4'd3, 48'd6));
		drain();
		write_reg(REG_MAX_HISTORY, CFG_W'(0));           // append then evict at once
		write_reg(REG_MIN_INTERVAL, '0);
		send_item(make_raise(4'd7, 48'd0));
		send_item(make_raise(4'd7, 48'd0));
		drain();
		write_reg(REG_MAX_HISTORY, CFG_W'(511));         // above depth acts as depth
	endtask

	// fill the ring past full, then lower the history limit to 4
	task automatic test_full_and_wrap();
		for (int i = 0; i < 270; i++)
			send_item(make_raise(4'($urandom_range(15)), 48'(i)));
		send_item(make_ack(mdl_next_id - 32'd100));
		drain();
		write_reg(REG_MAX_HISTORY, CFG_W'(4));
		for (int i = 0; i < 6; i++)
			send_item(make_raise(4'(i), 48'(i)));
		drain();
		// push id near wrap with throttled raises is too slow; use small history
		// and let ids run past 2^32 via many throttled raises is impractical, so
		// the counter is checked through the natural stream only.
	endtask

	task automatic test_random(input int unsigned n);
		req_t        r;
		int unsigned k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 55) begin
				now_ms += 48'($urandom_range(mdl_min_interval > 3000 ? 3000 :
					mdl_min_interval * 2 + 2));
				r = make_raise(4'($urandom), now_ms);
				if ($urandom_range(19) == 0)
					r.time_ms = TIME_W'({$urandom, $urandom});
			end else if (k < 85) begin
				r = make_ack(mdl_next_id - ID_W'($urandom_range(1, 40)));
			end else begin
				r = make_ack($urandom);
			end
			send_item(r);
		end
	endtask

	task automatic set_idling(input int unsigned s, input int unsigned rr);
		send_idle_pct = s;
		recv_stall_pct = rr;
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = REG_MIN_INTERVAL;
		cfg_data = '0;
		rsp_ready = 1'b1;
		error_count = 0;
		rsp_count = 0;
		items_sent = 0;
		now_ms = '0;
		set_idling(0, 0);
		mdl_min_interval = MIN_INTERVAL_RST;
		mdl_max_history = MAX_HISTORY_RST;
		for (int i = 0; i < TYPES; i++) begin
			mdl_type_seen[i] = 1'b0;
			mdl_last_time[i] = '0;
		end
		for (int i = 0; i < DEPTH; i++) begin
			mdl_entry_acked[i] = 1'b0;
			mdl_entry_id[i] = '0;
		end
		mdl_head = 0;
		mdl_count = 0;
		mdl_next_id = ID_W'(1);
		mdl_pending = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_and_wrap();
		write_reg(REG_MIN_INTERVAL, 32'd500);
		write_reg(REG_MAX_HISTORY, CFG_W'(32));
		set_idling(0, 0);
		test_random(230);
		drain();
		write_reg(REG_MIN_INTERVAL, 32'd0);
		write_reg(REG_MAX_HISTORY, CFG_W'(256));
		set_idling(66, 0);
		test_random(230);
		drain();
		write_reg(REG_MIN_INTERVAL, 32'd1000);
		write_reg(REG_MAX_HISTORY, CFG_W'(1));
		set_idling(0, 66);
		test_random(230);
		drain();
		write_reg(REG_MIN_INTERVAL, 32'd200);
		write_reg(REG_MAX_HISTORY, CFG_W'(100));
		set_idling(11, 11);
		test_random(230);
		set_idling(0, 0);
		drain();

		$display("covered %0d items, %0d results: throttling, ring eviction, acknowledge",
			items_sent, rsp_count);
		$display("history settings 0..511 and intervals 0..max under four idling mixes");
		if (error_count == 0 && expected_rsps.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

[filelist.f]
src/tel_pkg.sv
src/tel_cell.sv
src/tel_chain.sv
src/throttled_event_log_unit.sv
bench/throttled_event_log_unit_test.sv
